### hw/rtl/inverse_time_overcurrent_3ph_top_assert.svh
// ----------------------------------------------------------------------------
// itoc assertion macros
// shared concurrent check forms, clocked on clk_i and held off during reset
// ----------------------------------------------------------------------------
`ifndef INVERSE_TIME_OVERCURRENT_3PH_TOP_ASSERT_SVH
`define INVERSE_TIME_OVERCURRENT_3PH_TOP_ASSERT_SVH

// same-cycle implication
`define ITOC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITOC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/itoc_pkg.sv
// ----------------------------------------------------------------------------
// itoc_pkg
// shared types, constants and the root table of the overcurrent relay
// ----------------------------------------------------------------------------
package itoc_pkg;

  // timer width and limits
  localparam int TimerBits = 32;
  localparam logic [TimerBits-1:0] TimerMax = '1;
  localparam logic [63:0] TimerMaxW = (64'd1 << TimerBits) - 64'd1;
  localparam logic signed [63:0] RemLimit = 64'sd4294967295;

  localparam int CurW = 16;
  localparam int NumPhases = 3;
  localparam logic [1:0] LastPhase = 2'd2;

  // configuration port
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] RegPickup = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDial   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoefA  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoefB  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCoefC  = 3'd4;

  localparam int InDataW = 48;
  localparam int OutDataW = 48;
  localparam int MinW = 33;

  typedef struct packed {
    logic [15:0] pickup;
    logic [15:0] dial;
    logic [23:0] coef_a;
    logic [23:0] coef_b;
    logic [15:0] coef_c;
  } cfg_t;

  // one classified sample
  typedef struct packed {
    logic [NumPhases-1:0][CurW-1:0] cur;
    logic [NumPhases-1:0]           above;
    logic [CurW-1:0]                pk;
  } item_t;

  typedef struct packed {
    logic            start;
    logic [CurW-1:0] cur;
    logic [CurW-1:0] pk;
  } curve_req_t;

  typedef struct packed {
    logic                 done;
    logic [TimerBits-1:0] trip;
  } curve_rsp_t;

  typedef enum logic [3:0] {
    CsIdle, CsDiv, CsNorm, CsSqr, CsExp, CsPow, CsShift, CsSum, CsScale, CsDone
  } curve_state_e;

  typedef enum logic [1:0] {
    BsIdle, BsPhase, BsWait, BsEmit
  } back_state_e;

  // integer square root, evaluated at elaboration
  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] v;
    r = '0;
    v = x;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^-k) in Q1.30 by repeated square roots
  function automatic logic [31:0] root_val(int k);
    logic [63:0] t;
    t = 64'd1 << 31;
    for (int j = 1; j <= 16; j++) begin
      if (j <= k) t = isqrt64(t << 30);
    end
    return t[31:0];
  endfunction

  // entry n holds the root for k = n + 1
  localparam logic [31:0] RootTab [16] = '{
    root_val(1),  root_val(2),  root_val(3),  root_val(4),
    root_val(5),  root_val(6),  root_val(7),  root_val(8),
    root_val(9),  root_val(10), root_val(11), root_val(12),
    root_val(13), root_val(14), root_val(15), root_val(16)
  };

endpackage

### hw/rtl/itoc_fifo.sv
// ----------------------------------------------------------------------------
// itoc_fifo
// two-entry queue of classified samples between front and back
// ----------------------------------------------------------------------------
module itoc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  itoc_pkg::item_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output itoc_pkg::item_t rdata_o
);

  itoc_pkg::item_t mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  // pointers and fill count
  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    if (!push_i && pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_q];

endmodule

### hw/rtl/itoc_front.sv
// ----------------------------------------------------------------------------
// itoc_front
// accepts samples and marks the phases above the pickup level
// ----------------------------------------------------------------------------
module itoc_front (
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // current_a [15:0], current_b [31:16], current_c [47:32]
  input  logic [itoc_pkg::InDataW-1:0] s_axis_tdata,
  input  logic [15:0]                  pickup_i,
  input  logic                         full_i,
  output logic                         push_o,
  output itoc_pkg::item_t              item_o
);

  logic [itoc_pkg::CurW-1:0] pk;

  // a zero pickup acts as one
  assign pk = (pickup_i == 16'd0) ? 16'd1 : pickup_i;

  assign s_axis_tready = ~full_i;
  assign push_o        = s_axis_tvalid & ~full_i;

  // classify each phase
  always_comb begin
    item_o.pk = pk;
    for (int i = 0; i < itoc_pkg::NumPhases; i++) begin
      item_o.cur[i]   = s_axis_tdata[i*itoc_pkg::CurW +: itoc_pkg::CurW];
      item_o.above[i] = s_axis_tdata[i*itoc_pkg::CurW +: itoc_pkg::CurW] > pk;
    end
  end

endmodule

### hw/rtl/itoc_curve.sv
// ----------------------------------------------------------------------------
// itoc_curve
// sequential trip-time engine: ratio divide, log2, exponent, exp2, divide,
// scale
// ----------------------------------------------------------------------------
module itoc_curve (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  itoc_pkg::cfg_t        cfg_i,
  input  itoc_pkg::curve_req_t  req_i,
  output itoc_pkg::curve_rsp_t  rsp_o
);

  localparam logic [5:0] DivRatioSteps = 6'd32;
  localparam logic [5:0] DivNumSteps   = 6'd40;

  itoc_pkg::curve_state_e state_q, state_d;

  logic [5:0]  cnt_q, cnt_d;
  logic [3:0]  step_q, step_d;
  logic        div_num_q, div_num_d;
  logic [47:0] num_q, num_d;
  logic [47:0] den_q, den_d;
  logic [47:0] rem_q, rem_d;
  logic [47:0] quo_q, quo_d;
  logic [31:0] m_q, m_d;
  logic [3:0]  ip_q, ip_d;
  logic [15:0] frac_q, frac_d;
  logic [15:0] g_q, g_d;
  logic [7:0]  ei_q, ei_d;
  logic [30:0] f_q, f_d;
  logic [40:0] s_q, s_d;
  logic [itoc_pkg::TimerBits-1:0] trip_q, trip_d;

  logic [48:0] rs, diff;
  logic        ge;
  logic [47:0] quo_nx;
  logic [61:0] sq;
  logic [31:0] sh;
  logic [35:0] ep;
  logic [62:0] fp;
  logic [55:0] fsh;
  logic [41:0] dd;
  logic [56:0] tp;
  logic [63:0] tw;

  // shared arithmetic
  always_comb begin
    rs     = {rem_q, num_q[47]};
    diff   = rs - {1'b0, den_q};
    ge     = (rs >= {1'b0, den_q});
    quo_nx = {quo_q[46:0], ge};
    sq     = m_q[30:0] * m_q[30:0];
    sh     = sq[61:30];
    ep     = {ip_q, frac_q} * cfg_i.coef_c;
    fp     = f_q * itoc_pkg::RootTab[step_q];
    fsh    = 56'(f_q) << ei_q[4:0];
    dd     = fsh[55:14] - 42'd65536;
    tp     = s_q * cfg_i.dial;
    tw     = 64'(tp[56:20]);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      itoc_pkg::CsIdle:  if (req_i.start) state_d = itoc_pkg::CsDiv;
      itoc_pkg::CsDiv: begin
        if (cnt_q == 6'd1) state_d = div_num_q ? itoc_pkg::CsSum : itoc_pkg::CsNorm;
      end
      itoc_pkg::CsNorm:  if (m_q[31] || m_q[30]) state_d = itoc_pkg::CsSqr;
      itoc_pkg::CsSqr:   if (step_q == 4'd15) state_d = itoc_pkg::CsExp;
      itoc_pkg::CsExp:   state_d = (ep[35:28] >= 8'd26) ? itoc_pkg::CsSum : itoc_pkg::CsPow;
      itoc_pkg::CsPow:   if (step_q == 4'd15) state_d = itoc_pkg::CsShift;
      itoc_pkg::CsShift: state_d = (dd == 42'd0) ? itoc_pkg::CsDone : itoc_pkg::CsDiv;
      itoc_pkg::CsSum:   state_d = itoc_pkg::CsScale;
      itoc_pkg::CsScale: state_d = itoc_pkg::CsDone;
      itoc_pkg::CsDone:  state_d = itoc_pkg::CsIdle;
      default:           state_d = itoc_pkg::CsIdle;
    endcase
  end

  // datapath updates
  always_comb begin
    cnt_d     = cnt_q;
    step_d    = step_q;
    div_num_d = div_num_q;
    num_d     = num_q;
    den_d     = den_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    m_d       = m_q;
    ip_d      = ip_q;
    frac_d    = frac_q;
    g_d       = g_q;
    ei_d      = ei_q;
    f_d       = f_q;
    s_d       = s_q;
    trip_d    = trip_q;
    case (state_q)
      itoc_pkg::CsIdle: begin
        // ratio = cur * 2^16 / pickup
        num_d     = {req_i.cur, 32'd0};
        den_d     = 48'(req_i.pk);
        rem_d     = '0;
        quo_d     = '0;
        cnt_d     = DivRatioSteps;
        div_num_d = 1'b0;
      end
      itoc_pkg::CsDiv: begin
        // one quotient bit per cycle
        rem_d = ge ? diff[47:0] : rs[47:0];
        quo_d = quo_nx;
        num_d = {num_q[46:0], 1'b0};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1 && !div_num_q) begin
          m_d  = quo_nx[31:0];
          ip_d = 4'd14;
        end
      end
      itoc_pkg::CsNorm: begin
        // bring the leading one to bit 30
        step_d = 4'd0;
        frac_d = '0;
        if (m_q[31]) begin
          m_d  = {1'b0, m_q[31:1]};
          ip_d = 4'd15;
        end else if (!m_q[30]) begin
          m_d  = {m_q[30:0], 1'b0};
          ip_d = ip_q - 4'd1;
        end
      end
      itoc_pkg::CsSqr: begin
        // one fraction bit per squaring
        m_d    = sh[31] ? {1'b0, sh[31:1]} : sh;
        frac_d = {frac_q[14:0], sh[31]};
        step_d = step_q + 4'd1;
      end
      itoc_pkg::CsExp: begin
        ei_d   = ep[35:28];
        g_d    = ep[27:12];
        f_d    = 31'd1 << 30;
        step_d = 4'd0;
        quo_d  = '0;
      end
      itoc_pkg::CsPow: begin
        if (g_q[15]) f_d = fp[60:30];
        g_d    = {g_q[14:0], 1'b0};
        step_d = step_q + 4'd1;
      end
      itoc_pkg::CsShift: begin
        if (dd == 42'd0) begin
          trip_d = itoc_pkg::TimerMax;
        end else begin
          num_d     = {cfg_i.coef_b, 24'd0};
          den_d     = 48'(dd);
          rem_d     = '0;
          quo_d     = '0;
          cnt_d     = DivNumSteps;
          div_num_d = 1'b1;
        end
      end
      itoc_pkg::CsSum: begin
        s_d = 41'(cfg_i.coef_a) + 41'(quo_q[39:0]);
      end
      itoc_pkg::CsScale: begin
        trip_d = (tw > itoc_pkg::TimerMaxW) ? itoc_pkg::TimerMax
                                            : tw[itoc_pkg::TimerBits-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoc_pkg::CsIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    step_q    <= step_d;
    div_num_q <= div_num_d;
    num_q     <= num_d;
    den_q     <= den_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    m_q       <= m_d;
    ip_q      <= ip_d;
    frac_q    <= frac_d;
    g_q       <= g_d;
    ei_q      <= ei_d;
    f_q       <= f_d;
    s_q       <= s_d;
    trip_q    <= trip_d;
  end

  assign rsp_o.done = (state_q == itoc_pkg::CsDone);
  assign rsp_o.trip = trip_q;

endmodule

### hw/rtl/itoc_back.sv
// ----------------------------------------------------------------------------
// itoc_back
// per-phase timers and trip latches, result assembly and output register
// ----------------------------------------------------------------------------
`include "inverse_time_overcurrent_3ph_top_assert.svh"

module itoc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  itoc_pkg::item_t               item_i,
  output logic                          pop_o,
  output itoc_pkg::curve_req_t          curve_req_o,
  input  itoc_pkg::curve_rsp_t          curve_rsp_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [itoc_pkg::OutDataW-1:0] m_data_o
);

  localparam int RemW = itoc_pkg::TimerBits + 1;

  itoc_pkg::back_state_e state_q, state_d;

  logic [1:0]                     ph_q, ph_d;
  logic [itoc_pkg::TimerBits-1:0] elapsed_q [itoc_pkg::NumPhases];
  logic [itoc_pkg::TimerBits-1:0] el_wr;
  logic                           el_we;
  logic [2:0]                     pick_q, pick_d;
  logic [2:0]                     trip_q, trip_d;
  logic                           ev_q, ev_d;
  logic                           have_q, have_d;
  logic signed [RemW-1:0]         best_q, best_d;
  logic                           m_valid_q, m_valid_d;
  logic [itoc_pkg::OutDataW-1:0]  m_data_q;

  logic [itoc_pkg::TimerBits-1:0] el_cur, el_inc;
  logic signed [RemW-1:0]         rem;
  logic signed [63:0]             best_w, best_c;
  logic                           out_free, out_load;

  assign out_free = ~m_valid_q | m_ready_i;
  assign el_cur   = elapsed_q[ph_q];
  assign el_inc   = (el_cur != itoc_pkg::TimerMax) ? el_cur + 1'b1 : el_cur;
  assign rem      = $signed({1'b0, curve_rsp_i.trip}) - $signed({1'b0, el_inc});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      itoc_pkg::BsIdle:  if (q_valid_i) state_d = itoc_pkg::BsPhase;
      itoc_pkg::BsPhase: begin
        if (item_i.above[ph_q]) state_d = itoc_pkg::BsWait;
        else if (ph_q == itoc_pkg::LastPhase) state_d = itoc_pkg::BsEmit;
      end
      itoc_pkg::BsWait: begin
        if (curve_rsp_i.done) begin
          state_d = (ph_q == itoc_pkg::LastPhase) ? itoc_pkg::BsEmit : itoc_pkg::BsPhase;
        end
      end
      itoc_pkg::BsEmit:  if (out_free) state_d = itoc_pkg::BsIdle;
      default:           state_d = itoc_pkg::BsIdle;
    endcase
  end

  // phase sequencing and state updates
  always_comb begin
    ph_d        = ph_q;
    pick_d      = pick_q;
    trip_d      = trip_q;
    ev_d        = ev_q;
    have_d      = have_q;
    best_d      = best_q;
    el_we       = 1'b0;
    el_wr       = '0;
    pop_o       = 1'b0;
    out_load    = 1'b0;
    curve_req_o = '{start: 1'b0, cur: item_i.cur[ph_q], pk: item_i.pk};
    case (state_q)
      itoc_pkg::BsIdle: begin
        ph_d   = 2'd0;
        ev_d   = 1'b0;
        have_d = 1'b0;
        best_d = '0;
      end
      itoc_pkg::BsPhase: begin
        if (item_i.above[ph_q]) begin
          curve_req_o.start = 1'b1;
        end else begin
          // drop out
          if (pick_q[ph_q] || trip_q[ph_q]) ev_d = 1'b1;
          pick_d[ph_q] = 1'b0;
          trip_d[ph_q] = 1'b0;
          el_we        = 1'b1;
          ph_d         = ph_q + 2'd1;
        end
      end
      itoc_pkg::BsWait: begin
        if (curve_rsp_i.done) begin
          if (!pick_q[ph_q]) ev_d = 1'b1;
          pick_d[ph_q] = 1'b1;
          el_we        = 1'b1;
          el_wr        = el_inc;
          if (el_inc > curve_rsp_i.trip) begin
            if (!trip_q[ph_q]) ev_d = 1'b1;
            trip_d[ph_q] = 1'b1;
          end
          if (!have_q || rem < best_q) begin
            best_d = rem;
            have_d = 1'b1;
          end
          ph_d = ph_q + 2'd1;
        end
      end
      itoc_pkg::BsEmit: begin
        if (out_free) begin
          pop_o    = 1'b1;
          out_load = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // clamp of the least remaining time
  always_comb begin
    best_w = 64'(best_q);
    best_c = best_w;
    if (best_w > itoc_pkg::RemLimit) best_c = itoc_pkg::RemLimit;
    if (best_w < -itoc_pkg::RemLimit) best_c = -itoc_pkg::RemLimit;
  end

  assign m_valid_d = out_load ? 1'b1 : (m_ready_i ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= itoc_pkg::BsIdle;
      ph_q      <= 2'd0;
      pick_q    <= '0;
      trip_q    <= '0;
      ev_q      <= 1'b0;
      have_q    <= 1'b0;
      best_q    <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < itoc_pkg::NumPhases; i++) elapsed_q[i] <= '0;
    end else begin
      state_q   <= state_d;
      ph_q      <= ph_d;
      pick_q    <= pick_d;
      trip_q    <= trip_d;
      ev_q      <= ev_d;
      have_q    <= have_d;
      best_q    <= best_d;
      m_valid_q <= m_valid_d;
      if (el_we) elapsed_q[ph_q] <= el_wr;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {6'd0, best_c[itoc_pkg::MinW-1:0], ev_q, |trip_q, |pick_q,
                   trip_q, pick_q};
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  `ITOC_ASSERT_IMP(a_trip_needs_pick, 1'b1, (trip_q & ~pick_q) == 3'b000,
                   "trip latched on a phase that is not picked up")
  `ITOC_ASSERT_IMP(a_idle_timer_clear, 1'b1, (pick_q[0] || elapsed_q[0] == '0) && (pick_q[1] || elapsed_q[1] == '0) && (pick_q[2] || elapsed_q[2] == '0),
                   "timer running on a dropped-out phase")
  `ITOC_ASSERT_IMP(a_done_in_wait, curve_rsp_i.done, state_q == itoc_pkg::BsWait,
                   "trip time delivered while no phase waits for it")
  `ITOC_ASSERT_NXT(a_load_shows, out_load, m_valid_q,
                   "result word loaded but not offered")

endmodule

### hw/rtl/inverse_time_overcurrent_3ph_top.sv
// ----------------------------------------------------------------------------
// inverse_time_overcurrent_3ph_top
// samples: handled one at a time, phase by phase; the trip-time engine
//   (up to two bit-serial divides, 16 squarings, 16 root products) is shared
//   by the three phases
// reset: asynchronous, active low; clears timers and flags, loads register
//   defaults
// ----------------------------------------------------------------------------
module inverse_time_overcurrent_3ph_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // current_a [15:0], current_b [31:16], current_c [47:32]
  input  logic [itoc_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pickup_phase_a [0], pickup_phase_b [1], pickup_phase_c [2],
  // trip_phase_a [3], trip_phase_b [4], trip_phase_c [5], any_pickup [6],
  // any_trip [7], change_event [8], min_remaining [41:9], zero [47:42]
  output logic [itoc_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [itoc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [itoc_pkg::CfgDataW-1:0] cfg_data_i
);

  itoc_pkg::cfg_t       cfg_q, cfg_d;
  itoc_pkg::item_t      front_item, q_item;
  itoc_pkg::curve_req_t curve_req;
  itoc_pkg::curve_rsp_t curve_rsp;
  logic                 push, full, pop, q_valid;

  assign cfg_ready_o = 1'b1;

  // register writes, unknown indexes dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        itoc_pkg::RegPickup: cfg_d.pickup = cfg_data_i[15:0];
        itoc_pkg::RegDial:   cfg_d.dial   = cfg_data_i[15:0];
        itoc_pkg::RegCoefA:  cfg_d.coef_a = cfg_data_i;
        itoc_pkg::RegCoefB:  cfg_d.coef_b = cfg_data_i;
        itoc_pkg::RegCoefC:  cfg_d.coef_c = cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pickup: 16'd1000, dial: 16'd4096, coef_a: 24'd0,
                 coef_b: 24'd35840, coef_c: 16'd82};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  itoc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .pickup_i      (cfg_q.pickup),
    .full_i        (full),
    .push_o        (push),
    .item_o        (front_item)
  );

  itoc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_item)
  );

  itoc_curve u_curve (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .req_i  (curve_req),
    .rsp_o  (curve_rsp)
  );

  itoc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .curve_req_o (curve_req),
    .curve_rsp_i (curve_rsp),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

endmodule
